// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro expects clk in scope; TAK_ASSERT also expects rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TAK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tak: assertion failed");
`define TAK_ASSERT_NORST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tak: assertion failed during reset");
`else
`define TAK_ASSERT(label, prop)
`define TAK_ASSERT_NORST(label, prop)
`endif
`endif

// ----- design/tak_pkg.sv -----
package tak_pkg;

  localparam int VW = 32;
  localparam int FB = 16;
  localparam int UF_W = 10;
  localparam int WIDE_W = 2 * VW + 2;
  localparam int DIV_LAT = VW + 1;
  localparam int PIPE_LAT = 2 * DIV_LAT + 8;

  typedef logic signed [VW-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam val_t ONE_Q = VW'(1 << FB);
  localparam val_t ZERO_Q = '0;

  localparam logic [1:0] OP_MOTORS = 2'd0;
  localparam logic [1:0] OP_DRIVES = 2'd1;
  localparam logic [1:0] OP_AXES = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [2:0] REG_BASE_LENGTH = 3'd0;
  localparam logic [2:0] REG_ROT_ORIGIN = 3'd1;
  localparam logic [2:0] REG_FIRST_SCALE = 3'd2;
  localparam logic [2:0] REG_SECOND_SCALE = 3'd3;
  localparam logic [2:0] REG_FIRST_OFFSET = 3'd4;
  localparam logic [2:0] REG_SECOND_OFFSET = 3'd5;
  localparam logic [2:0] REG_OMIT_OFFSETS = 3'd6;
  localparam logic [2:0] REG_UNIT_FACTOR = 3'd7;

  typedef struct packed {
    logic [1:0] opcode;
    val_t first_value;
    val_t second_value;
  } in_t;

  typedef struct packed {
    val_t translation;
    val_t angle;
    val_t first_drive;
    val_t second_drive;
    val_t first_motor;
    val_t second_motor;
    logic status;
  } out_t;

  // Per-transaction context carried down the pipeline.
  typedef struct packed {
    logic [1:0] op;
    logic err;
    val_t a;
    val_t b;
    val_t d1;
    val_t d2;
    val_t x2;
    val_t t;
    val_t u;
    logic sg1;
    logic sg2;
    logic sg3;
  } ctx_t;

  function automatic val_t sat_wide(input logic signed [WIDE_W-1:0] x);
    if (x > WIDE_W'(VAL_MAX)) return VAL_MAX;
    if (x < WIDE_W'(VAL_MIN)) return VAL_MIN;
    return x[VW-1:0];
  endfunction

  // Saturate a divider quotient magnitude with its sign.
  function automatic val_t sat_quot(input logic neg, input logic ovf,
                                    input logic [VW-1:0] q);
    if (neg) begin
      if (ovf || q > VW'(VAL_MIN)) return VAL_MIN;
      return val_t'(~q + 1'b1);
    end
    if (ovf || q[VW-1]) return VAL_MAX;
    return val_t'(q);
  endfunction

  function automatic logic [2*VW-1:0] mag_wide(input logic signed [2*VW-1:0] p);
    return p[2*VW-1] ? (2*VW)'(-p) : (2*VW)'(p);
  endfunction

  function automatic logic [VW-1:0] mag_val(input val_t v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  function automatic logic [VW:0] mag_diff(input logic signed [VW:0] v);
    return v[VW] ? (VW+1)'(-v) : (VW+1)'(v);
  endfunction

  // Product scaled down by the fraction bits, truncated toward zero.
  function automatic logic signed [WIDE_W-1:0] trunc_frac(
      input logic signed [2*VW-1:0] p);
    logic [2*VW-1:0] m;
    m = mag_wide(p) >> FB;
    return p[2*VW-1] ? -WIDE_W'(m) : WIDE_W'(m);
  endfunction

endpackage

// ----- design/tak_div.sv -----
module tak_div import tak_pkg::*; (
  input  logic            clk,
  input  logic [2*VW-1:0] num,
  input  logic [VW-1:0]   den,
  output logic            ovf,
  output logic [VW-1:0]   quo
);

  // Restoring division, one quotient bit per stage; quotient bits shift into low.
  logic [VW-1:0] rem [0:VW-1];
  logic [VW-1:0] low [0:VW];
  logic [VW-1:0] dvs [0:VW-1];
  logic          ovf_r [0:VW];

  always_ff @(posedge clk) begin
    rem[0] <= num[2*VW-1:VW];
    low[0] <= num[VW-1:0];
    dvs[0] <= den;
    ovf_r[0] <= num[2*VW-1:VW] >= den;
  end

  for (genvar k = 1; k <= VW; k++) begin : g_step
    logic [VW:0] trial;
    logic [VW:0] diff;
    assign trial = {rem[k-1], low[k-1][VW-1]};
    assign diff = trial - {1'b0, dvs[k-1]};
    always_ff @(posedge clk) begin
      low[k] <= {low[k-1][VW-2:0], ~diff[VW]};
      ovf_r[k] <= ovf_r[k-1];
    end
    if (k < VW) begin : g_rem
      always_ff @(posedge clk) begin
        rem[k] <= diff[VW] ? trial[VW-1:0] : diff[VW-1:0];
        dvs[k] <= dvs[k-1];
      end
    end
  end

  assign quo = low[VW];
  assign ovf = ovf_r[VW];

endmodule

// ----- design/two_actuator_support_kinematics_core.sv -----
// Channel   | Signals                         | Handshake
// ----------+---------------------------------+------------------------------------
// command   | start, busy, cmd (in_t)         | taken when start && !busy
// result    | done, result (out_t)            | one cycle per strobe, no back-pressure
// config    | cfg_we, cfg_index, cfg_data     | written when cfg_we is high
//
// One transaction enters every cycle; busy stays low.
// Each result passes through two pipelined dividers of VW+1 stages each, plus
// eight stages of multiply, scale and saturate logic around them.
// Synchronous rst clears all valid bits and restores the register defaults.
// Nothing stalls: the receiver takes every result in its strobe cycle.
`include "assert_macros.svh"

module two_actuator_support_kinematics_core import tak_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         cmd,
  output logic        done,
  output out_t        result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [VW-1:0] cfg_data
);

  // ---------------- configuration registers ----------------
  val_t base_length, rot_origin, first_scale, second_scale;
  val_t first_offset, second_offset;
  logic omit_offsets;
  logic [UF_W-1:0] unit_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length <= ONE_Q;
      rot_origin <= ZERO_Q;
      first_scale <= ONE_Q;
      second_scale <= ONE_Q;
      first_offset <= ZERO_Q;
      second_offset <= ZERO_Q;
      omit_offsets <= 1'b0;
      unit_factor <= UF_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_LENGTH:   base_length <= cfg_data;
        REG_ROT_ORIGIN:    rot_origin <= cfg_data;
        REG_FIRST_SCALE:   first_scale <= cfg_data;
        REG_SECOND_SCALE:  second_scale <= cfg_data;
        REG_FIRST_OFFSET:  first_offset <= cfg_data;
        REG_SECOND_OFFSET: second_offset <= cfg_data;
        REG_OMIT_OFFSETS:  omit_offsets <= cfg_data[0];
        REG_UNIT_FACTOR:   unit_factor <= cfg_data[UF_W-1:0];
        default: ;
      endcase
    end
  end

  // Offsets drop out when omitted; config is to be kept stable by the user while transactions fly (not enforced here).
  val_t off1, off2;
  logic [VW-1:0] uf_den;
  assign off1 = omit_offsets ? ZERO_Q : first_offset;
  assign off2 = omit_offsets ? ZERO_Q : second_offset;
  assign uf_den = VW'(unit_factor);

  assign busy = 1'b0;

  // ---------------- stage 1: classify, first multiplies ----------------
  logic s1_valid;
  ctx_t s1_ctx, s1_ctx_next;
  logic signed [2*VW-1:0] s1_p1, s1_p2;
  val_t mul_a1, mul_b1, mul_b2;
  logic accept;

  assign accept = start && !busy;

  always_comb begin
    s1_ctx_next = '0;
    s1_ctx_next.op = cmd.opcode;
    s1_ctx_next.a = cmd.first_value;
    s1_ctx_next.b = cmd.second_value;
    s1_ctx_next.err = (unit_factor == '0) || (cmd.opcode == OP_RSVD) ||
                      (cmd.opcode != OP_AXES && base_length == '0) ||
                      (cmd.opcode != OP_MOTORS &&
                       (first_scale == '0 || second_scale == '0));
    // Axes transactions share the multipliers for b*rot_origin and b*base_length.
    mul_a1 = (cmd.opcode == OP_AXES) ? cmd.second_value : cmd.first_value;
    mul_b1 = (cmd.opcode == OP_AXES) ? rot_origin : first_scale;
    mul_b2 = (cmd.opcode == OP_AXES) ? base_length : second_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= accept;
    s1_ctx <= s1_ctx_next;
    s1_p1 <= mul_a1 * mul_b1;
    s1_p2 <= cmd.second_value * mul_b2;
  end

  // ---------------- stage 2: drive positions or axis numerators ----------------
  logic s2_valid;
  ctx_t s2_ctx, s2_ctx_next;
  logic [2*VW-1:0] s2_n1, s2_n2;

  always_comb begin
    s2_ctx_next = s1_ctx;
    s2_ctx_next.sg1 = s1_p1[2*VW-1];
    s2_ctx_next.sg2 = s1_p2[2*VW-1];
    if (s1_ctx.op == OP_MOTORS) begin
      // Saturate the scaled motor position before the offset is added.
      s2_ctx_next.d1 = sat_wide(WIDE_W'(sat_wide(trunc_frac(s1_p1))) + WIDE_W'(off1));
      s2_ctx_next.d2 = sat_wide(WIDE_W'(sat_wide(trunc_frac(s1_p2))) + WIDE_W'(off2));
    end else begin
      s2_ctx_next.d1 = s1_ctx.a;
      s2_ctx_next.d2 = s1_ctx.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
    s2_ctx <= s2_ctx_next;
    s2_n1 <= mag_wide(s1_p1) >> FB;
    s2_n2 <= mag_wide(s1_p2) >> FB;
  end

  // ---------------- stage 3: first divider operands ----------------
  logic s3_valid;
  ctx_t s3_ctx, s3_ctx_next;
  logic [2*VW-1:0] s3_num1, s3_num2, num1_next;
  logic [VW-1:0] s3_den1, s3_den2, den1_next;
  logic signed [VW:0] dd;
  logic [VW+UF_W:0] prod_uf;

  always_comb begin
    s3_ctx_next = s2_ctx;
    dd = (VW+1)'(s2_ctx.d1) - (VW+1)'(s2_ctx.d2);
    prod_uf = mag_diff(dd) * unit_factor;
    if (s2_ctx.op == OP_AXES) begin
      num1_next = s2_n1;
      den1_next = uf_den;
    end else begin
      // angle = (d1 - d2) * unit_factor / base_length, in Q format
      num1_next = (2*VW)'(prod_uf) << FB;
      den1_next = mag_val(base_length);
      s3_ctx_next.sg1 = dd[VW] ^ base_length[VW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else s3_valid <= s2_valid;
    s3_ctx <= s3_ctx_next;
    s3_num1 <= num1_next;
    s3_den1 <= den1_next;
    s3_num2 <= s2_n2;
    s3_den2 <= uf_den;
  end

  // ---------------- first divider bank ----------------
  logic ovf1, ovf2;
  logic [VW-1:0] q1, q2;

  tak_div u_div_1a (.clk(clk), .num(s3_num1), .den(s3_den1), .ovf(ovf1), .quo(q1));
  tak_div u_div_1b (.clk(clk), .num(s3_num2), .den(s3_den2), .ovf(ovf2), .quo(q2));

  ctx_t dl1_ctx [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] dl1_valid;

  always_ff @(posedge clk) begin
    if (rst) dl1_valid <= '0;
    else dl1_valid <= {dl1_valid[DIV_LAT-2:0], s3_valid};
    dl1_ctx[0] <= s3_ctx;
    for (int i = 1; i < DIV_LAT; i++) dl1_ctx[i] <= dl1_ctx[i-1];
  end

  // ---------------- stage 4: saturate first quotients ----------------
  logic s4_valid;
  ctx_t s4_ctx, s4_ctx_next;
  val_t v1, v2;

  always_comb begin
    s4_ctx_next = dl1_ctx[DIV_LAT-1];
    v1 = sat_quot(dl1_ctx[DIV_LAT-1].sg1, ovf1, q1);
    v2 = sat_quot(dl1_ctx[DIV_LAT-1].sg2, ovf2, q2);
    s4_ctx_next.x2 = v1;
    s4_ctx_next.t = v1;
    s4_ctx_next.u = v2;
  end

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else s4_valid <= dl1_valid[DIV_LAT-1];
    s4_ctx <= s4_ctx_next;
  end

  // ---------------- stage 5: angle * rot_origin, or second drive ----------------
  logic s5_valid;
  ctx_t s5_ctx, s5_ctx_next;
  logic signed [2*VW-1:0] s5_prod;

  always_comb begin
    s5_ctx_next = s4_ctx;
    if (s4_ctx.op == OP_AXES)
      s5_ctx_next.d2 = sat_wide(WIDE_W'(s4_ctx.a) + WIDE_W'(s4_ctx.t));
  end

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else s5_valid <= s4_valid;
    s5_ctx <= s5_ctx_next;
    s5_prod <= s4_ctx.x2 * rot_origin;
  end

  // ---------------- stage 6: scale product, or first drive ----------------
  logic s6_valid;
  ctx_t s6_ctx, s6_ctx_next;
  logic [2*VW-1:0] s6_nx;

  always_comb begin
    s6_ctx_next = s5_ctx;
    s6_ctx_next.sg3 = s5_prod[2*VW-1];
    if (s5_ctx.op == OP_AXES)
      s6_ctx_next.d1 = sat_wide(WIDE_W'(s5_ctx.d2) + WIDE_W'(s5_ctx.u));
  end

  always_ff @(posedge clk) begin
    if (rst) s6_valid <= 1'b0;
    else s6_valid <= s5_valid;
    s6_ctx <= s6_ctx_next;
    s6_nx <= mag_wide(s5_prod) >> FB;
  end

  // ---------------- stage 7: second divider operands ----------------
  logic s7_valid;
  ctx_t s7_ctx, s7_ctx_next;
  logic [2*VW-1:0] s7_num_a, s7_num_b, s7_num_c;
  logic [VW-1:0] s7_den_a, s7_den_b, s7_den_c;
  logic signed [VW:0] eb, ec;

  always_comb begin
    s7_ctx_next = s6_ctx;
    eb = (VW+1)'(s6_ctx.d1) - (VW+1)'(off1);
    ec = (VW+1)'(s6_ctx.d2) - (VW+1)'(off2);
    s7_ctx_next.sg1 = eb[VW] ^ first_scale[VW-1];
    s7_ctx_next.sg2 = ec[VW] ^ second_scale[VW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) s7_valid <= 1'b0;
    else s7_valid <= s6_valid;
    s7_ctx <= s7_ctx_next;
    s7_num_a <= s6_nx;
    s7_den_a <= uf_den;
    s7_num_b <= (2*VW)'(mag_diff(eb)) << FB;
    s7_den_b <= mag_val(first_scale);
    s7_num_c <= (2*VW)'(mag_diff(ec)) << FB;
    s7_den_c <= mag_val(second_scale);
  end

  // ---------------- second divider bank ----------------
  logic ovf_a, ovf_b, ovf_c;
  logic [VW-1:0] qa, qb, qc;

  tak_div u_div_2a (.clk(clk), .num(s7_num_a), .den(s7_den_a), .ovf(ovf_a), .quo(qa));
  tak_div u_div_2b (.clk(clk), .num(s7_num_b), .den(s7_den_b), .ovf(ovf_b), .quo(qb));
  tak_div u_div_2c (.clk(clk), .num(s7_num_c), .den(s7_den_c), .ovf(ovf_c), .quo(qc));

  ctx_t dl2_ctx [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] dl2_valid;

  always_ff @(posedge clk) begin
    if (rst) dl2_valid <= '0;
    else dl2_valid <= {dl2_valid[DIV_LAT-2:0], s7_valid};
    dl2_ctx[0] <= s7_ctx;
    for (int i = 1; i < DIV_LAT; i++) dl2_ctx[i] <= dl2_ctx[i-1];
  end

  // ---------------- stage 8: assemble the result ----------------
  ctx_t fc;
  val_t xq, x1, m1, m2;
  out_t result_next;

  always_comb begin
    fc = dl2_ctx[DIV_LAT-1];
    xq = sat_quot(fc.sg3, ovf_a, qa);
    x1 = sat_wide(WIDE_W'(fc.d2) - WIDE_W'(xq));
    m1 = sat_quot(fc.sg1, ovf_b, qb);
    m2 = sat_quot(fc.sg2, ovf_c, qc);
    result_next = '0;
    if (fc.err) begin
      result_next.status = 1'b1;
    end else begin
      case (fc.op)
        OP_MOTORS: begin
          result_next.translation = x1;
          result_next.angle = fc.x2;
          result_next.first_drive = fc.d1;
          result_next.second_drive = fc.d2;
        end
        OP_DRIVES: begin
          result_next.translation = x1;
          result_next.angle = fc.x2;
          result_next.first_motor = m1;
          result_next.second_motor = m2;
        end
        OP_AXES: begin
          result_next.first_drive = fc.d1;
          result_next.second_drive = fc.d2;
          result_next.first_motor = m1;
          result_next.second_motor = m2;
        end
        default: result_next.status = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dl2_valid[DIV_LAT-1];
    result <= result_next;
  end

  // ---------------- checks ----------------
  `TAK_ASSERT_NORST(a_reset_quiet, rst |=> !done)
  `TAK_ASSERT(a_fixed_latency, done |-> $past(start, PIPE_LAT))
  `TAK_ASSERT(a_error_clears, done && result.status |->
    result.translation == '0 && result.angle == '0 && result.first_drive == '0 &&
    result.second_drive == '0 && result.first_motor == '0 &&
    result.second_motor == '0)
  `TAK_ASSERT(a_axes_no_axis_out, done && $past(cmd.opcode == OP_AXES, PIPE_LAT) |->
    result.translation == '0 && result.angle == '0)

endmodule
